FILE: rtl/lstk_pkg.sv
// ----------------------------------------------------------------------------
// lstk_pkg
// Shared types and codes of the LIFO stack with in-place reverse.
// ----------------------------------------------------------------------------
package lstk_pkg;

	localparam int WORD_W   = 32;
	localparam int CMD_W    = 2;
	localparam int FILL_W   = 5;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic signed [WORD_W-1:0] top_value;
		logic [FILL_W-1:0]        fill_count;
		logic [STATUS_W-1:0]      status;
	} rsp_t;

	// finished request from the sequencer
	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} fin_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_REV_RD_LO,
		ST_REV_RD_HI,
		ST_REV_WR_LO,
		ST_REV_WR_HI
	} state_t;

endpackage

FILE: rtl/lifo_stack_with_reverse.sv
// Push, refused commands, no-ops, pops that empty the stack and
//   reverses of fewer than two words raise done in the cycle after start.
// A pop with two or more words first reads the store to refill the top.
// Reverse of n words: floor(n/2) pair swaps, one store access per cycle.
// Push takes one request per cycle; busy stays low while idle.
// Reset clears the count and the sequencer; the word store is not cleared.
// ----------------------------------------------------------------------------
// lifo_stack_with_reverse
// Fixed-depth stack of signed words with push, pop and in-place reverse.
// ----------------------------------------------------------------------------
module lifo_stack_with_reverse #(
	parameter int STACK_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lstk_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output lstk_pkg::rsp_t rsp
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	lstk_pkg::fin_t fin;
	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic signed [lstk_pkg::WORD_W-1:0] mem_wdata;
	logic                               mem_re;
	logic [AW-1:0]                      mem_raddr;
	logic signed [lstk_pkg::WORD_W-1:0] mem_rdata;
	logic                               done_q;
	lstk_pkg::rsp_t                     rsp_q;

	lstk_seq #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW         (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.fin      (fin),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	lstk_mem #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW         (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin.valid) begin
			rsp_q <= fin.rsp;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/lstk_mem.sv
// ----------------------------------------------------------------------------
// lstk_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lstk_mem #(
	parameter int STACK_DEPTH = 16,
	parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [lstk_pkg::WORD_W-1:0]  wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [lstk_pkg::WORD_W-1:0]  rdata
);

	logic signed [lstk_pkg::WORD_W-1:0] mem [STACK_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/lstk_seq.sv
// ----------------------------------------------------------------------------
// lstk_seq
// Command sequencer: count and cached top word, pop refill read and the
// pairwise swap loop of reverse, all through the word store.
// ----------------------------------------------------------------------------
module lstk_seq #(
	parameter int STACK_DEPTH = 16,
	parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  lstk_pkg::req_t                      req,
	output logic                                busy,
	output lstk_pkg::fin_t                      fin,
	output logic                                mem_we,
	output logic [AW-1:0]                       mem_waddr,
	output logic signed [lstk_pkg::WORD_W-1:0]  mem_wdata,
	output logic                                mem_re,
	output logic [AW-1:0]                       mem_raddr,
	input  logic signed [lstk_pkg::WORD_W-1:0]  mem_rdata
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
	localparam logic [CW:0]   TWO      = (CW+1)'(2);

	lstk_pkg::state_t state_q, state_n;
	logic [CW-1:0] count_q, count_n;
	logic signed [lstk_pkg::WORD_W-1:0] top_q, top_n;
	logic signed [lstk_pkg::WORD_W-1:0] popped_q, popped_n;
	logic signed [lstk_pkg::WORD_W-1:0] save_q, save_n;
	logic [AW-1:0] lo_q, lo_n, hi_q, hi_n;
	logic signed [lstk_pkg::WORD_W-1:0] cur_top;

	assign busy    = (state_q != lstk_pkg::ST_IDLE);
	assign cur_top = (count_q == '0) ? '0 : top_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lstk_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		top_q    <= top_n;
		popped_q <= popped_n;
		save_q   <= save_n;
		lo_q     <= lo_n;
		hi_q     <= hi_n;
	end

	// next state, memory access and finished request
	always_comb begin
		state_n   = state_q;
		count_n   = count_q;
		top_n     = top_q;
		popped_n  = popped_q;
		save_n    = save_q;
		lo_n      = lo_q;
		hi_n      = hi_q;
		mem_we    = 1'b0;
		mem_waddr = lo_q;
		mem_wdata = req.push_value;
		mem_re    = 1'b0;
		mem_raddr = lo_q;
		fin.valid = 1'b0;
		fin.rsp.popped_value = '0;
		fin.rsp.top_value    = cur_top;
		fin.rsp.fill_count   = lstk_pkg::FILL_W'(count_q);
		fin.rsp.status       = lstk_pkg::STAT_OK;

		unique case (state_q)
			lstk_pkg::ST_IDLE: begin
				if (start) begin
					unique case (req.cmd)
						lstk_pkg::CMD_PUSH: begin
							fin.valid = 1'b1;
							if (count_q == FULL_CNT) begin
								fin.rsp.status = lstk_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = req.push_value;
								count_n   = count_q + CW'(1);
								top_n     = req.push_value;
								fin.rsp.top_value  = req.push_value;
								fin.rsp.fill_count = lstk_pkg::FILL_W'(count_n);
							end
						end
						lstk_pkg::CMD_POP: begin
							if (count_q == '0) begin
								fin.valid      = 1'b1;
								fin.rsp.status = lstk_pkg::STAT_EMPTY;
							end else if ({1'b0, count_q} >= TWO) begin
								// new top lies below, fetch it
								count_n   = count_q - CW'(1);
								popped_n  = top_q;
								mem_re    = 1'b1;
								mem_raddr = AW'(count_q - CW'(2));
								state_n   = lstk_pkg::ST_POP_RD;
							end else begin
								count_n = '0;
								fin.valid = 1'b1;
								fin.rsp.popped_value = top_q;
								fin.rsp.top_value    = '0;
								fin.rsp.fill_count   = '0;
							end
						end
						lstk_pkg::CMD_REVERSE: begin
							if ({1'b0, count_q} >= TWO) begin
								lo_n    = '0;
								hi_n    = AW'(count_q - CW'(1));
								state_n = lstk_pkg::ST_REV_RD_LO;
							end else begin
								fin.valid = 1'b1;
							end
						end
						default: begin
							// unused code acts as a no-op
							fin.valid = 1'b1;
						end
					endcase
				end
			end
			lstk_pkg::ST_POP_RD: begin
				top_n     = mem_rdata;
				fin.valid = 1'b1;
				fin.rsp.popped_value = popped_q;
				fin.rsp.top_value    = mem_rdata;
				state_n   = lstk_pkg::ST_IDLE;
			end
			lstk_pkg::ST_REV_RD_LO: begin
				mem_re    = 1'b1;
				mem_raddr = lo_q;
				state_n   = lstk_pkg::ST_REV_RD_HI;
			end
			lstk_pkg::ST_REV_RD_HI: begin
				mem_re    = 1'b1;
				mem_raddr = hi_q;
				save_n    = mem_rdata;
				state_n   = lstk_pkg::ST_REV_WR_LO;
			end
			lstk_pkg::ST_REV_WR_LO: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = mem_rdata;
				state_n   = lstk_pkg::ST_REV_WR_HI;
			end
			lstk_pkg::ST_REV_WR_HI: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = save_q;
				// bottom word becomes the new top on the first pair
				if (lo_q == '0) begin
					top_n = save_q;
				end
				lo_n = lo_q + AW'(1);
				hi_n = hi_q - AW'(1);
				if (({1'b0, lo_q} + (AW+1)'(2)) < {1'b0, hi_q}) begin
					state_n = lstk_pkg::ST_REV_RD_LO;
				end else begin
					state_n   = lstk_pkg::ST_IDLE;
					fin.valid = 1'b1;
					fin.rsp.top_value = top_n;
				end
			end
			default: begin
				state_n = lstk_pkg::ST_IDLE;
			end
		endcase
	end

	// the count never passes the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stack count above depth");

	// a read never meets a write to the same entry
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write to the same entry");

	// a request that does not finish at once keeps the sequencer busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !fin.valid) |=> busy)
		else $error("unfinished request left the sequencer idle");

	// swap reads and the first write never finish a request
	a_swap_no_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lstk_pkg::ST_REV_RD_LO || state_q == lstk_pkg::ST_REV_RD_HI ||
		 state_q == lstk_pkg::ST_REV_WR_LO) |-> !fin.valid)
		else $error("request finished in the middle of a swap");

	// a pop refill always finishes the request
	a_pop_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lstk_pkg::ST_POP_RD) |-> (fin.valid && state_n == lstk_pkg::ST_IDLE))
		else $error("pop refill did not finish");

endmodule

FILE: tb/tb_lifo_stack_with_reverse.sv
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_reverse
// Self-checking bench for the stack: a directed opening covers the empty,
// single-word and full corners plus every command code. Random traffic then
// swings the fill level between empty and full while the sender idles at
// different rates. A scoreboard class keeps its own copy of the stack and
// compares every response, field by field, in order.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_reverse;
	import lstk_pkg::*;

	localparam int          STACK_DEPTH  = 16;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned TAIL_CYCLES  = 4 * (STACK_DEPTH / 2) + 8;
	localparam int unsigned MAX_REPORTS  = 40;

	// unused command code, the block treats it as a no-op
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	// direction the random command mix leans toward
	typedef enum int {
		LEAN_FILL,
		LEAN_DRAIN,
		LEAN_EVEN
	} lean_t;

	// scoreboard: shadow stack plus the responses still owed by the block
	class lifo_scoreboard;
		logic signed [WORD_W-1:0] words [STACK_DEPTH];
		int unsigned              depth_used;
		rsp_t                     rsp_due_q [$];
		int unsigned              requests;
		int unsigned              checked;
		int unsigned              errors;
		int unsigned              full_hits;
		int unsigned              empty_hits;
		int unsigned              reversals;
		int unsigned              peak_depth;

		function new();
			depth_used = 0;
			requests   = 0;
			checked    = 0;
			errors     = 0;
			full_hits  = 0;
			empty_hits = 0;
			reversals  = 0;
			peak_depth = 0;
		endfunction

		// apply one request to the shadow stack and build the response it owes
		function rsp_t step_stack(req_t r);
			rsp_t                     o;
			int                       lo;
			int                       hi;
			logic signed [WORD_W-1:0] tmp;
			o = '0;
			o.status = STAT_OK;
			case (r.cmd)
				CMD_PUSH: begin
					if (depth_used >= STACK_DEPTH) begin
						o.status = STAT_FULL;
						full_hits++;
					end else begin
						words[depth_used] = r.push_value;
						depth_used++;
					end
				end
				CMD_POP: begin
					if (depth_used == 0) begin
						o.status = STAT_EMPTY;
						empty_hits++;
					end else begin
						depth_used--;
						o.popped_value = words[depth_used];
					end
				end
				CMD_REVERSE: begin
					reversals++;
					lo = 0;
					hi = int'(depth_used) - 1;
					while (lo < hi) begin
						tmp       = words[lo];
						words[lo] = words[hi];
						words[hi] = tmp;
						lo++;
						hi--;
					end
				end
				default: begin
				end
			endcase
			if (depth_used > peak_depth)
				peak_depth = depth_used;
			o.top_value  = (depth_used == 0) ? '0 : words[depth_used-1];
			o.fill_count = FILL_W'(depth_used);
			return o;
		endfunction

		function void note_request(req_t r);
			requests++;
			rsp_due_q.push_back(step_stack(r));
		endfunction

		function void flag(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s wrong, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (rsp_due_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: response with none due, expected nothing, actual %h",
						$time, got);
				return;
			end
			want = rsp_due_q.pop_front();
			checked++;
			if (got.popped_value !== want.popped_value)
				flag("popped_value", want.popped_value, got.popped_value);
			if (got.top_value !== want.top_value)
				flag("top_value", want.top_value, got.top_value);
			if (got.fill_count !== want.fill_count)
				flag("fill_count", WORD_W'(want.fill_count), WORD_W'(got.fill_count));
			if (got.status !== want.status)
				flag("status", WORD_W'(want.status), WORD_W'(got.status));
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           start;
	req_t           req;
	logic           busy;
	logic           done;
	rsp_t           rsp;
	int unsigned    cycles = 0;
	lifo_scoreboard sb = new();

	lifo_stack_with_reverse #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d responses still due",
				cycles, sb.rsp_due_q.size());
			$display("lifo_stack_with_reverse: mismatch");
			$finish;
		end
	end

	// note accepted requests and check responses at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(req);
			if (done)
				sb.check_response(rsp);
		end
	end

	function automatic req_t make_req(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] value);
		req_t r;
		r.cmd        = cmd;
		r.push_value = value;
		return r;
	endfunction

	// words weighted toward the extremes, otherwise fully random
	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic req_t random_req(lean_t lean);
		int unsigned pct;
		int unsigned push_pct;
		pct      = $urandom_range(0, 99);
		push_pct = (lean == LEAN_FILL) ? 60 : (lean == LEAN_DRAIN) ? 20 : 42;
		if (pct < 4)
			return make_req(CMD_NOP, random_word());
		if (pct < 16)
			return make_req(CMD_REVERSE, random_word());
		if (pct < 16 + push_pct)
			return make_req(CMD_PUSH, random_word());
		return make_req(CMD_POP, random_word());
	endfunction

	// present one request at a falling edge and hold it until taken
	task automatic send_request(req_t r, int unsigned idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every due response has come back
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (sb.rsp_due_q.size() != 0);
	endtask

	task automatic run_random(int unsigned idle_pct, int unsigned count);
		lean_t lean;
		lean = LEAN_FILL;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0)
				lean = lean_t'($urandom_range(0, 2));
			send_request(random_req(lean), idle_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty corners, single word, extremes, no-op, full
		send_request(make_req(CMD_POP, 32'h1234_5678), 0);
		send_request(make_req(CMD_REVERSE, '1), 0);
		send_request(make_req(CMD_PUSH, 32'h8000_0000), 0);
		send_request(make_req(CMD_REVERSE, '0), 0);
		send_request(make_req(CMD_PUSH, 32'h7fff_ffff), 0);
		send_request(make_req(CMD_PUSH, '1), 0);
		send_request(make_req(CMD_PUSH, '0), 0);
		send_request(make_req(CMD_REVERSE, 32'h5555_aaaa), 0);
		send_request(make_req(CMD_NOP, 32'haaaa_5555), 0);
		send_request(make_req(CMD_POP, '0), 0);
		for (int i = 0; i < 13; i++)
			send_request(make_req(CMD_PUSH, $urandom()), 0);
		send_request(make_req(CMD_PUSH, 32'hdead_beef), 0);
		send_request(make_req(CMD_REVERSE, '0), 0);

		// random traffic at three sender idle rates
		run_random(15, 485);
		wait_drained();
		run_random(83, 485);
		wait_drained();
		run_random(0, 480);
		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("%0d requests, %0d responses checked, deepest fill %0d of %0d",
			sb.requests, sb.checked, sb.peak_depth, STACK_DEPTH);
		$display("%0d pushes refused full, %0d pops refused empty, %0d reverses",
			sb.full_hits, sb.empty_hits, sb.reversals);
		if (sb.errors == 0 && sb.rsp_due_q.size() == 0)
			$display("lifo_stack_with_reverse: match");
		else
			$display("lifo_stack_with_reverse: mismatch");
		$finish;
	end

endmodule
